>>> design/jpws_pkg.sv
// Shared types and constants of the joint position window smoother.
package jpws_pkg;

  localparam int JOINTS      = 16;
  localparam int JOINT_W     = 4;
  localparam int SLOT_W      = 2;
  localparam int SLOT_MAX    = 4;
  localparam int COORD_W     = 16;
  localparam int CONF_W      = 8;
  localparam int AXES        = 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [CONF_W-1:0]  CONF_RESET = 8'd128;
  localparam logic [JOINT_W-1:0] LEFT_HIP   = 4'd9;
  localparam logic [JOINT_W-1:0] RIGHT_HIP  = 4'd12;
  localparam logic [JOINT_W-1:0] WAIST      = 4'd15;
  localparam logic               CMD_SAMPLE = 1'b0;
  localparam logic               CMD_CLEAR  = 1'b1;
  // Bias between an offset-binary quotient and its two's complement value
  localparam logic [COORD_W-1:0] SIGN_FLIP  = 16'h8000;

  // Class of a request after the front end has looked at it
  typedef enum logic [1:0] {
    K_SAMPLE,
    K_CLEAR,
    K_SKIP
  } kind_t;

  // Back end sequencer states
  typedef enum logic [2:0] {
    B_IDLE,
    B_JRD,
    B_RRD,
    B_DIV,
    B_OUT
  } bstate_t;

  // Raw request as it arrives on the input channel
  typedef struct packed {
    logic                              cmd;
    logic [SLOT_W-1:0]                 slot;
    logic [JOINT_W-1:0]                joint;
    logic [AXES-1:0][COORD_W-1:0]      pos;
    logic [CONF_W-1:0]                 conf;
  } in_item_t;

  // Classified request handed from front to back
  typedef struct packed {
    kind_t                             kind;
    logic [SLOT_W-1:0]                 slot;
    logic [JOINT_W-1:0]                joint;
    logic                              slot_ok;
    logic                              valid;
    logic [AXES-1:0][COORD_W-1:0]      raw;
  } item_t;

  // One result
  typedef struct packed {
    logic [SLOT_W-1:0]                 slot;
    logic [JOINT_W-1:0]                joint;
    logic [AXES-1:0][COORD_W-1:0]      avg;
    logic                              held;
    logic                              cleared;
  } res_t;

endpackage

>>> design/joint_position_window_smoother_unit.sv
// Top level of the joint position window smoother: ports, threshold register, checks.
// A request passes the queue, then the back end states: idle, joint read, ring read,
// divide, output. Held samples skip the ring read; clears and out-of-range slots go
// from idle straight to output. A new request waits until the last one leaves output,
// as set by the back end's read-modify-write of the sum memory and the ring memory.
// Reset: synchronous, active low; threshold returns to 128, all filter state reads as zero.
module joint_position_window_smoother_unit import jpws_pkg::*; #(
  parameter int WINDOW  = 8,
  parameter int PLAYERS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // player_slot, joint, pos_x, pos_y, pos_z, confidence, pad
  input  logic        in_tuser,   // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // out_slot, out_joint, avg_x, avg_y, avg_z, pad
  output logic [1:0]  out_tuser,  // held, cleared
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data    // confidence_threshold
);

  logic [CONF_W-1:0] thresh_r;
  in_item_t          in_item;
  item_t             q_in, q_head;
  logic              q_push, q_full, q_pop, q_nempty;
  res_t              res;

  // Unpack the input request
  always_comb begin
    in_item.cmd    = in_tuser;
    in_item.slot   = in_tdata[1:0];
    in_item.joint  = in_tdata[5:2];
    in_item.pos[0] = in_tdata[21:6];
    in_item.pos[1] = in_tdata[37:22];
    in_item.pos[2] = in_tdata[53:38];
    in_item.conf   = in_tdata[61:54];
  end

  // Threshold register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= CONF_RESET;
    end else if (cfg_valid && cfg_ready) begin
      thresh_r <= cfg_data;
    end
  end

  jpws_front #(
    .PLAYERS (PLAYERS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .threshold (thresh_r),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_in)
  );

  jpws_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .head_item (q_head),
    .not_empty (q_nempty)
  );

  jpws_back #(
    .WINDOW  (WINDOW),
    .PLAYERS (PLAYERS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (q_head),
    .item_valid (q_nempty),
    .item_pop   (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_res    (res)
  );

  // Pack the result
  assign out_tdata = {2'b00, res.avg[2], res.avg[1], res.avg[0], res.joint, res.slot};
  assign out_tuser = {res.cleared, res.held};

  // A clear acknowledgment is never also a held result
  a_clear_not_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("clear result flagged as held");

  // A clear acknowledgment carries zero means
  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1]) |-> (out_tdata[53:6] == 48'd0))
    else $error("clear result with nonzero mean");

  // No result is offered right after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result valid after reset");

  // A request cannot enter while the queue is full
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !in_tready)
    else $error("input ready while queue full");

endmodule

>>> design/jpws_front.sv
// Front end: classifies requests, keeps the hip latches and forms the waist value.
module jpws_front import jpws_pkg::*; #(
  parameter int PLAYERS = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  in_item_t          in_item,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CONF_W-1:0] threshold,
  input  logic              q_full,
  output logic              q_push,
  output item_t             q_item
);

  localparam int NSLOT  = (PLAYERS < SLOT_MAX) ? PLAYERS : SLOT_MAX;
  localparam int HIP_IW = (NSLOT > 1) ? $clog2(NSLOT) : 1;

  logic [AXES-1:0][COORD_W-1:0] lhip_pos_r [NSLOT];
  logic [AXES-1:0][COORD_W-1:0] rhip_pos_r [NSLOT];
  logic [NSLOT-1:0]             lhip_ok_r;
  logic [NSLOT-1:0]             rhip_ok_r;
  logic [HIP_IW-1:0]            hidx;
  logic                         slot_ok;
  logic                         conf_ok;
  logic                         is_left;
  logic                         is_right;
  logic [COORD_W:0]             hip_sum [AXES];

  // Stall the input only while the queue is full
  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;
  assign hidx     = in_item.slot[HIP_IW-1:0];

  // Classify the request and build the value to filter
  always_comb begin
    slot_ok  = int'(in_item.slot) < PLAYERS;
    conf_ok  = in_item.conf >= threshold;
    is_left  = (in_item.cmd == CMD_SAMPLE) && slot_ok && (in_item.joint == LEFT_HIP);
    is_right = (in_item.cmd == CMD_SAMPLE) && slot_ok && (in_item.joint == RIGHT_HIP);

    q_item.slot    = in_item.slot;
    q_item.joint   = in_item.joint;
    q_item.slot_ok = slot_ok;
    if (in_item.cmd == CMD_CLEAR) begin
      q_item.kind = K_CLEAR;
    end else if (slot_ok) begin
      q_item.kind = K_SAMPLE;
    end else begin
      q_item.kind = K_SKIP;
    end

    for (int a = 0; a < AXES; a++) begin
      hip_sum[a] = {lhip_pos_r[hidx][a][COORD_W-1], lhip_pos_r[hidx][a]}
                 + {rhip_pos_r[hidx][a][COORD_W-1], rhip_pos_r[hidx][a]};
    end

    if (in_item.joint == WAIST) begin
      // Waist: floor mean of the latched hips
      q_item.valid = lhip_ok_r[hidx] && rhip_ok_r[hidx];
      for (int a = 0; a < AXES; a++) begin
        q_item.raw[a] = hip_sum[a][COORD_W:1];
      end
    end else begin
      q_item.valid = conf_ok;
      q_item.raw   = in_item.pos;
    end
  end

  // Latch hip validity; drop it on a clear of the slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lhip_ok_r <= '0;
      rhip_ok_r <= '0;
    end else if (q_push) begin
      if (in_item.cmd == CMD_CLEAR && slot_ok) begin
        lhip_ok_r[hidx] <= 1'b0;
        rhip_ok_r[hidx] <= 1'b0;
      end
      if (is_left) begin
        lhip_ok_r[hidx] <= conf_ok;
      end
      if (is_right) begin
        rhip_ok_r[hidx] <= conf_ok;
      end
    end
  end

  // Latch hip positions
  always_ff @(posedge clk) begin
    if (q_push && is_left) begin
      lhip_pos_r[hidx] <= in_item.pos;
    end
    if (q_push && is_right) begin
      rhip_pos_r[hidx] <= in_item.pos;
    end
  end

endmodule

>>> design/jpws_queue.sv
// Short request queue between the front and back ends.
module jpws_queue import jpws_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output item_t head_item,
  output logic  not_empty
);

  item_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   count_r;

  assign full      = count_r == (QPTR_W+1)'(QUEUE_DEPTH);
  assign not_empty = count_r != '0;
  assign head_item = mem_r[rd_ptr_r];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (QPTR_W+1)'(1);
      end
    end
  end

  // Hold entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> design/jpws_back.sv
// Back end: ring and sum read-modify-write, floor divide by the window, result register.
module jpws_back import jpws_pkg::*; #(
  parameter int WINDOW  = 8,
  parameter int PLAYERS = 4
) (
  input  logic  clk,
  input  logic  rst_n,
  input  item_t item,
  input  logic  item_valid,
  output logic  item_pop,
  output logic  out_valid,
  input  logic  out_ready,
  output res_t  out_res
);

  localparam int NSLOT      = (PLAYERS < SLOT_MAX) ? PLAYERS : SLOT_MAX;
  localparam int ROWS       = NSLOT * JOINTS;
  localparam int ROW_W      = $clog2(ROWS);
  localparam int PTR_W      = $clog2(WINDOW);
  localparam int SUM_W      = COORD_W + PTR_W;
  localparam int JST_W      = AXES * SUM_W + PTR_W + 1;
  localparam int RING_AW    = ROW_W + PTR_W;
  localparam int RING_DEPTH = ROWS * (1 << PTR_W);
  localparam int U_W        = SUM_W;
  localparam int SHIFT      = U_W + PTR_W;
  localparam int RECIP_W    = U_W + 2;
  localparam int PROD_W     = U_W + RECIP_W;
  localparam int CAT_W      = SLOT_W + JOINT_W;

  // Reciprocal of the window, exact for every biased sum below 2**U_W
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
  // Bias that makes every sum non-negative; quotient then carries +2**15
  localparam logic [U_W:0]       OFFSET   = (U_W+1)'(64'(WINDOW) << (COORD_W - 1));
  localparam logic [PTR_W-1:0]   LAST_POS = PTR_W'(WINDOW - 1);

  bstate_t                      state_r, state_nxt;
  item_t                        it_r;
  logic [JST_W-1:0]             jst_mem [ROWS];
  logic [JST_W-1:0]             jst_rd_r;
  logic [JST_W-1:0]             jst_wdata;
  logic                         jst_we;
  logic [ROWS-1:0]              jvalid_r, jvalid_nxt;
  logic [AXES*COORD_W-1:0]      ring_mem [RING_DEPTH];
  logic [AXES-1:0][COORD_W-1:0] ring_rd_r;
  logic                         ring_we;
  logic [CAT_W-1:0]             head_cat, cur_cat;
  logic [ROW_W-1:0]             head_row, cur_row;
  logic [RING_AW-1:0]           ring_addr;
  logic                         row_ok;
  logic [AXES-1:0][SUM_W-1:0]   sum_r, cur_sum, new_sum;
  logic [AXES-1:0][COORD_W-1:0] old_val;
  logic [PTR_W-1:0]             pos_r, cur_pos, pos_next;
  logic                         full_r, cur_full, wrap;
  logic [U_W:0]                 u_ext [AXES];
  logic [AXES-1:0][PROD_W-1:0]  prod_r;
  logic                         out_valid_r, out_valid_nxt, out_free;
  res_t                         out_res_r, res_nxt;

  assign head_cat  = {item.slot, item.joint};
  assign cur_cat   = {it_r.slot, it_r.joint};
  assign head_row  = head_cat[ROW_W-1:0];
  assign cur_row   = cur_cat[ROW_W-1:0];
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // Decode the joint state; rows not written since reset or clear read as zero
  always_comb begin
    row_ok   = jvalid_r[cur_row];
    cur_full = row_ok & jst_rd_r[JST_W-1];
    cur_pos  = row_ok ? jst_rd_r[JST_W-2 -: PTR_W] : '0;
    cur_sum  = row_ok ? jst_rd_r[AXES*SUM_W-1:0] : '0;
    ring_addr = {cur_row, (state_r == B_JRD) ? cur_pos : pos_r};
  end

  // Replace the oldest entry and advance the ring position
  always_comb begin
    wrap     = pos_r == LAST_POS;
    pos_next = wrap ? '0 : pos_r + PTR_W'(1);
    old_val  = full_r ? ring_rd_r : '0;
    for (int a = 0; a < AXES; a++) begin
      new_sum[a] = sum_r[a]
                 - {{(SUM_W-COORD_W){old_val[a][COORD_W-1]}}, old_val[a]}
                 + {{(SUM_W-COORD_W){it_r.raw[a][COORD_W-1]}}, it_r.raw[a]};
      u_ext[a]   = {sum_r[a][SUM_W-1], sum_r[a]} + OFFSET;
    end
    jst_wdata = {full_r | wrap, pos_next, new_sum};
  end

  // Form the result from the quotient
  always_comb begin
    res_nxt.slot    = it_r.slot;
    res_nxt.joint   = it_r.joint;
    res_nxt.held    = (it_r.kind == K_SKIP) || ((it_r.kind == K_SAMPLE) && !it_r.valid);
    res_nxt.cleared = it_r.kind == K_CLEAR;
    for (int a = 0; a < AXES; a++) begin
      res_nxt.avg[a] = (it_r.kind == K_SAMPLE) ? (prod_r[a][SHIFT +: COORD_W] ^ SIGN_FLIP)
                                                : '0;
    end
  end

  // Sequencer: next state, pops, memory writes
  always_comb begin
    state_nxt  = state_r;
    item_pop   = 1'b0;
    jst_we     = 1'b0;
    ring_we    = 1'b0;
    jvalid_nxt = jvalid_r;
    unique case (state_r)
      B_IDLE: begin
        if (item_valid) begin
          item_pop  = 1'b1;
          state_nxt = (item.kind == K_SAMPLE) ? B_JRD : B_OUT;
          if (item.kind == K_CLEAR && item.slot_ok) begin
            for (int r = 0; r < ROWS; r++) begin
              if ((r >> JOINT_W) == int'(item.slot)) begin
                jvalid_nxt[r] = 1'b0;
              end
            end
          end
        end
      end
      B_JRD: begin
        state_nxt = it_r.valid ? B_RRD : B_DIV;
      end
      B_RRD: begin
        ring_we             = 1'b1;
        jst_we              = 1'b1;
        jvalid_nxt[cur_row] = 1'b1;
        state_nxt           = B_DIV;
      end
      B_DIV: begin
        state_nxt = B_OUT;
      end
      B_OUT: begin
        if (out_free) begin
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
    out_valid_nxt = out_valid_r && !out_ready;
    if (state_r == B_OUT && out_free) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      jvalid_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      jvalid_r    <= jvalid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (item_pop) begin
      it_r <= item;
    end
    if (state_r == B_JRD) begin
      sum_r  <= cur_sum;
      pos_r  <= cur_pos;
      full_r <= cur_full;
    end
    if (state_r == B_RRD) begin
      sum_r <= new_sum;
    end
    if (state_r == B_DIV) begin
      for (int a = 0; a < AXES; a++) begin
        prod_r[a] <= PROD_W'(u_ext[a][U_W-1:0]) * PROD_W'(RECIP);
      end
    end
    if (state_r == B_OUT && out_free) begin
      out_res_r <= res_nxt;
    end
  end

  // Joint state memory: sums, ring position, ring full flag
  always_ff @(posedge clk) begin
    if (jst_we) begin
      jst_mem[cur_row] <= jst_wdata;
    end
    jst_rd_r <= jst_mem[head_row];
  end

  // Ring memory: one port, read then written at the same entry
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[ring_addr] <= it_r.raw;
    end
    ring_rd_r <= ring_mem[ring_addr];
  end

endmodule

>>> test/joint_position_window_smoother_unit_tb.sv
// Self-checking testbench for the joint position window smoother: directed table, then random frames.
module joint_position_window_smoother_unit_tb import jpws_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN       = 8;
  localparam int PLAYERS_N = 4;
  localparam int PHASE_LEN = 175;

  // One result as it leaves the block
  typedef struct packed {
    logic [1:0]  slot;
    logic [3:0]  joint;
    logic [15:0] avg_x;
    logic [15:0] avg_y;
    logic [15:0] avg_z;
    logic        held;
    logic        cleared;
  } pose_mean_t;

  // One row of the directed table; the tail holds a typed-in answer when known
  typedef struct {
    logic               cmd;
    logic [1:0]         slot;
    logic [3:0]         joint;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] pz;
    logic [7:0]         conf;
    bit                 typed;
    logic [15:0]        ax;
    logic [15:0]        ay;
    logic [15:0]        az;
    logic               held;
    logic               cleared;
  } step_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;   // player_slot, joint, pos_x, pos_y, pos_z, confidence, pad
  logic        in_tuser;   // cmd
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;  // out_slot, out_joint, avg_x, avg_y, avg_z, pad
  logic [1:0]  out_tuser;  // held, cleared
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_data;   // confidence_threshold

  // Shadow filter state
  logic signed [15:0] ring_mem [PLAYERS_N][JOINTS][WIN][3];
  longint             axis_sum [PLAYERS_N][JOINTS][3];
  int unsigned        wr_pos   [PLAYERS_N][JOINTS];
  logic signed [15:0] lhip_pos [PLAYERS_N][3];
  logic signed [15:0] rhip_pos [PLAYERS_N][3];
  logic               lhip_ok  [PLAYERS_N];
  logic               rhip_ok  [PLAYERS_N];
  logic [7:0]         conf_floor;

  pose_mean_t  pending_means[$];
  step_row_t   plan[$];
  int          idle_pct;
  int          stall_pct;
  int          errors;
  int          items_sent;
  int          means_seen;
  int          held_seen;
  int          clears_seen;
  int          thr_seen_lo;
  int          thr_seen_hi;

  joint_position_window_smoother_unit #(
    .WINDOW (WIN),
    .PLAYERS(PLAYERS_N)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Free-running clock, 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Zero every ring, sum, position and hip latch of one slot
  function automatic void wipe_slot(int s);
    for (int j = 0; j < JOINTS; j++) begin
      wr_pos[s][j] = 0;
      for (int a = 0; a < 3; a++) begin
        axis_sum[s][j][a] = 0;
        for (int k = 0; k < WIN; k++) ring_mem[s][j][k][a] = '0;
      end
    end
    for (int a = 0; a < 3; a++) begin
      lhip_pos[s][a] = '0;
      rhip_pos[s][a] = '0;
    end
    lhip_ok[s] = 1'b0;
    rhip_ok[s] = 1'b0;
  endfunction

  // Mean rounded toward minus infinity
  function automatic longint floor_mean(longint s);
    longint q;
    q = s / WIN;
    if ((s % WIN) != 0 && s < 0) q -= 1;
    return q;
  endfunction

  // Apply one request to the shadow state and return the mean it should produce
  function automatic pose_mean_t smooth_predict(logic cmd, logic [1:0] slot, logic [3:0] joint,
                                                logic signed [15:0] px, logic signed [15:0] py,
                                                logic signed [15:0] pz, logic [7:0] conf);
    pose_mean_t         r;
    logic signed [15:0] raw [3];
    bit                 ok;
    int                 p;
    int                 hs;
    longint             q [3];
    r       = '0;
    r.slot  = slot;
    r.joint = joint;
    raw[0]  = px;
    raw[1]  = py;
    raw[2]  = pz;
    if (cmd == CMD_CLEAR) begin
      r.cleared = 1'b1;
      if (slot < PLAYERS_N) wipe_slot(slot);
    end else if (slot >= PLAYERS_N) begin
      r.held = 1'b1;
    end else begin
      if (joint == WAIST) begin
        // waist is the floored midpoint of the latched hips
        ok = lhip_ok[slot] && rhip_ok[slot];
        for (int a = 0; a < 3; a++) begin
          hs     = int'(lhip_pos[slot][a]) + int'(rhip_pos[slot][a]);
          raw[a] = 16'(hs >>> 1);
        end
      end else begin
        ok = (conf >= conf_floor);
        if (joint == LEFT_HIP) begin
          for (int a = 0; a < 3; a++) lhip_pos[slot][a] = raw[a];
          lhip_ok[slot] = ok;
        end else if (joint == RIGHT_HIP) begin
          for (int a = 0; a < 3; a++) rhip_pos[slot][a] = raw[a];
          rhip_ok[slot] = ok;
        end
      end
      if (ok) begin
        p = wr_pos[slot][joint] % WIN;
        for (int a = 0; a < 3; a++) begin
          axis_sum[slot][joint][a] -= ring_mem[slot][joint][p][a];
          axis_sum[slot][joint][a] += raw[a];
          ring_mem[slot][joint][p][a] = raw[a];
        end
        wr_pos[slot][joint] = (p + 1) % WIN;
      end else begin
        r.held = 1'b1;
      end
      for (int a = 0; a < 3; a++) q[a] = floor_mean(axis_sum[slot][joint][a]);
      r.avg_x = 16'(q[0]);
      r.avg_y = 16'(q[1]);
      r.avg_z = 16'(q[2]);
    end
    return r;
  endfunction

  // Send one request, idling first as the current phase asks; record its mean on acceptance
  task automatic issue(logic cmd, logic [1:0] slot, logic [3:0] joint, logic signed [15:0] px,
                       logic signed [15:0] py, logic signed [15:0] pz, logic [7:0] conf,
                       bit typed, pose_mean_t want);
    pose_mean_t m;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tdata  = {2'b00, conf, pz, py, px, joint, slot};
    in_tuser  = cmd;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    m = smooth_predict(cmd, slot, joint, px, py, pz, conf);
    pending_means.push_back(typed ? want : m);
    items_sent++;
  endtask

  // Drop the request line and wait until every outstanding mean has come back
  task automatic drain;
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
  endtask

  // Write the threshold while the block is idle
  task automatic set_threshold(logic [7:0] v);
    drain();
    repeat (10) @(posedge clk);
    @(negedge clk);
    cfg_data  = v;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    conf_floor = v;
    if (v == 8'd0) thr_seen_lo = 1;
    if (v == 8'hFF) thr_seen_hi = 1;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Coordinate mix: extremes, full range, and small values near the origin
  function automatic logic signed [15:0] pick_coord();
    int k;
    k = $urandom_range(7);
    if (k == 0) begin
      case ($urandom_range(3))
        0: return 16'sh8000;
        1: return 16'sh7FFF;
        2: return 16'sh0000;
        default: return 16'shFFFF;
      endcase
    end
    if (k < 3) return 16'($urandom);
    return 16'($urandom_range(4095) - 2048);
  endfunction

  task automatic cmp_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d (0x%0h), got %0d (0x%0h)",
               $time, name, want, want, got, got);
    end
  endtask

  // Receiver stalls, decided at the falling edge
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Check each accepted result against the oldest pending mean
  always @(posedge clk) begin
    pose_mean_t got;
    pose_mean_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[1:0], out_tdata[5:2], out_tdata[21:6], out_tdata[37:22],
             out_tdata[53:38], out_tuser[0], out_tuser[1]};
      means_seen++;
      if (got.held) held_seen++;
      if (got.cleared) clears_seen++;
      if (pending_means.size() == 0) begin
        errors++;
        $display("%0t ns: result with nothing pending, got 0x%0h", $time, got);
      end else begin
        want = pending_means.pop_front();
        cmp_field("out_slot", want.slot, got.slot);
        cmp_field("out_joint", want.joint, got.joint);
        cmp_field("avg_x", $signed(want.avg_x), $signed(got.avg_x));
        cmp_field("avg_y", $signed(want.avg_y), $signed(got.avg_y));
        cmp_field("avg_z", $signed(want.avg_z), $signed(got.avg_z));
        cmp_field("held", want.held, got.held);
        cmp_field("cleared", want.cleared, got.cleared);
      end
    end
  end

  // Hard stop for a hung run
  initial begin
    #20_000_000;
    $display("joint_position_window_smoother_unit_tb: errors");
    $finish;
  end

  initial begin
    step_row_t  row;
    pose_mean_t want;
    int         r;
    logic       cmd;
    logic [1:0] slot;
    logic [3:0] joint;
    logic [7:0] conf;
    logic [7:0] thr;
    clk         = 1'b0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = 1'b0;
    out_tready  = 1'b0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    idle_pct    = 0;
    stall_pct   = 0;
    errors      = 0;
    items_sent  = 0;
    means_seen  = 0;
    held_seen   = 0;
    clears_seen = 0;
    thr_seen_lo = 0;
    thr_seen_hi = 0;
    conf_floor  = CONF_RESET;
    for (int s = 0; s < PLAYERS_N; s++) wipe_slot(s);

    // Directed table, run at the reset threshold
    plan.push_back('{CMD_SAMPLE, 0, 0, 1, 2, 3, 127, 1, 0, 0, 0, 1, 0});
    plan.push_back('{CMD_SAMPLE, 0, 0, 800, -800, 8, 128, 1, 100, -100, 1, 0, 0});
    plan.push_back('{CMD_SAMPLE, 0, 0, 32767, -32768, -1, 255, 0, 0, 0, 0, 0, 0});
    plan.push_back('{CMD_SAMPLE, 1, LEFT_HIP, 100, -3, 32767, 200, 0, 0, 0, 0, 0, 0});
    plan.push_back('{CMD_SAMPLE, 1, RIGHT_HIP, -101, -32768, 32767, 128, 0, 0, 0, 0, 0, 0});
    plan.push_back('{CMD_SAMPLE, 1, WAIST, 5, 5, 5, 0, 0, 0, 0, 0, 0, 0});
    plan.push_back('{CMD_SAMPLE, 1, RIGHT_HIP, 7, 7, 7, 5, 0, 0, 0, 0, 0, 0});
    plan.push_back('{CMD_SAMPLE, 1, WAIST, 0, 0, 0, 255, 0, 0, 0, 0, 0, 0});
    plan.push_back('{CMD_SAMPLE, 2, WAIST, -1, -1, -1, 255, 1, 0, 0, 0, 1, 0});
    for (int k = 0; k < WIN + 1; k++)
      plan.push_back('{CMD_SAMPLE, 3, 5, 32767, -32768, 32767, 255, 0, 0, 0, 0, 0, 0});
    plan.push_back('{CMD_CLEAR, 3, 7, -1, -1, -1, 255, 1, 0, 0, 0, 0, 1});
    plan.push_back('{CMD_SAMPLE, 3, 5, 9, 9, 9, 0, 1, 0, 0, 0, 1, 0});
    plan.push_back('{CMD_CLEAR, 1, WAIST, 0, 0, 0, 0, 1, 0, 0, 0, 0, 1});
    plan.push_back('{CMD_SAMPLE, 1, WAIST, 0, 0, 0, 255, 1, 0, 0, 0, 1, 0});

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Walk the directed table
    foreach (plan[i]) begin
      row  = plan[i];
      want = {row.slot, row.joint, row.ax, row.ay, row.az, row.held, row.cleared};
      issue(row.cmd, row.slot, row.joint, row.px, row.py, row.pz, row.conf, row.typed, want);
    end

    // Random phases: each sets a threshold and an idle/stall mix
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: thr = 8'd0;
        1: thr = 8'hFF;
        2: thr = 8'd128;
        4: thr = 8'd1;
        5: thr = 8'd200;
        7: thr = 8'd64;
        default: thr = 8'($urandom_range(255));
      endcase
      set_threshold(thr);
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 80; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 80; end
        default: begin idle_pct = 29; stall_pct = 29; end
      endcase
      for (int n = 0; n < PHASE_LEN; n++) begin
        // in phase 5 only, hold off once mid-phase until the pipeline is empty
        if (ph == 5 && n == PHASE_LEN / 2) drain();
        r     = $urandom_range(99);
        cmd   = (r < 2) ? CMD_CLEAR : CMD_SAMPLE;
        slot  = 2'($urandom_range(PLAYERS_N - 1));
        if (r < 11) joint = LEFT_HIP;
        else if (r < 20) joint = RIGHT_HIP;
        else if (r < 32) joint = WAIST;
        else joint = 4'($urandom_range(15));
        // mostly confident samples so rings fill and wrap
        conf = ($urandom_range(99) < 70) ? 8'($urandom_range(255, conf_floor))
                                         : 8'($urandom_range(255));
        issue(cmd, slot, joint, pick_coord(), pick_coord(), pick_coord(), conf, 0, '0);
      end
    end

    drain();
    repeat (20) @(posedge clk);

    $display("Covered %0d requests across 8 threshold phases (0 and 255 included: %0d/%0d).",
             items_sent, thr_seen_lo, thr_seen_hi);
    $display("Checked %0d means: %0d held, %0d clear acknowledgments.",
             means_seen, held_seen, clears_seen);
    if (errors == 0 && pending_means.size() == 0) begin
      $display("joint_position_window_smoother_unit_tb: clean");
    end else begin
      if (pending_means.size() != 0)
        $display("%0t ns: %0d expected means never arrived", $time, pending_means.size());
      $display("joint_position_window_smoother_unit_tb: errors");
    end
    $finish;
  end

endmodule
